### rtl/core/desw_pkg.sv
// Shared constants and types for the disjoint exact-sum windows block.
// No dependencies; used by desw_dp and the top level.
`default_nettype none

package desw_pkg;

  localparam int DEF_MAX_ITEMS   = 4096;
  localparam int DEF_MAX_WINDOWS = 128;
  localparam int DEF_VALUE_BITS  = 16;

  localparam int TGT_W       = 28;
  localparam int WCNT_W      = 8;
  localparam int OUT_LEN_W   = 13;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 8'd1;

  localparam logic [TGT_W-1:0]  TGT_RESET  = 28'd1;
  localparam logic [WCNT_W-1:0] WCNT_RESET = 8'd1;

  typedef struct packed {
    logic done;
    logic ok;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/disjoint_exact_sum_windows_dp_top.sv
// Top level: load buffer, two-pointer window scan, config registers, result register.
// Depends on desw_pkg and desw_dp.
//
// Usage:
//   in_*  : one value word per beat (in_tdata), in_tlast closes the run. Words beyond
//           MAX_ITEMS are dropped; a tlast on a dropped word still closes the run.
//   out_* : one result word per closed run: best total length in out_tdata,
//           out_tuser high when the requested count of windows cannot be chosen.
//   cfg_* : register writes (index 0 target sum, 1 window count), always ready;
//           write only while the block is idle.
// Flow: after tlast the scan moves its two pointers with one value memory read per
//   pointer move, a check state then an add or subtract state; then the DP makes m
//   passes over the row memories, one position per cycle, for n loaded words and
//   window count m. A count of zero or above MAX_WINDOWS skips the scan and the DP.
//   in_tready is low from tlast until the result is in the output register.
// Reset clears control and sets target sum and window count to 1; no memory
//   clearing pass is needed. A stalled out_tready holds the result; the next
//   run loads meanwhile and waits for the register only at its end.
`default_nettype none

module disjoint_exact_sum_windows_dp_top import desw_pkg::*; #(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int MAX_WINDOWS = DEF_MAX_WINDOWS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [VALUE_BITS-1:0] item_value
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [12:0] best_length
  output logic                   out_tuser,  // [0] no_solution
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int LEN_W = $clog2(MAX_ITEMS + 1);
  localparam int ACC_W = ((TGT_W > VALUE_BITS) ? TGT_W : VALUE_BITS) + 1;

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_CHK    = 6'b000010,
    S_ADD    = 6'b000100,
    S_SUB    = 6'b001000,
    S_DP     = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] value_mem [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rd_data_r;

  logic [TGT_W-1:0]     target_r;
  logic [WCNT_W-1:0]    wcount_r;
  logic [LEN_W-1:0]     cnt_r, cnt_nxt, n_r, n_nxt, i_r, i_nxt, e_r, e_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [LEN_W-1:0]     res_len_r, res_len_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_LEN_W-1:0] out_len_r, out_len_nxt;
  logic                 out_fail_r, out_fail_nxt;

  logic                 in_acc, vs_we, cond, win_valid, win_we, dp_start;
  logic [LEN_W-1:0]     cnt_inc, i_inc, e_m1;
  logic [ACC_W-1:0]     tgt_ext;
  logic [IDX_W-1:0]     rd_addr;
  logic [LEN_W+OUT_LEN_W-1:0] len_ext;
  dp_stat_t             dp_stat;
  logic [LEN_W-1:0]     dp_len;

  assign in_tready  = (state_r == S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign vs_we      = in_acc && (cnt_r < LEN_W'(MAX_ITEMS));
  assign cnt_inc    = cnt_r + LEN_W'(vs_we);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_LEN_W){1'b0}}, out_len_r};
  assign out_tuser  = out_fail_r;

  assign tgt_ext   = ACC_W'(target_r);
  assign cond      = (e_r < n_r) && ((acc_r < tgt_ext) || (e_r == i_r));
  assign win_valid = (e_r > i_r) && (acc_r == tgt_ext);
  assign e_m1      = e_r - LEN_W'(1);
  assign i_inc     = i_r + LEN_W'(1);
  assign win_we    = (state_r == S_CHK) && !cond;
  assign rd_addr   = cond ? e_r[IDX_W-1:0] : i_r[IDX_W-1:0];
  assign len_ext   = {{OUT_LEN_W{1'b0}}, res_len_r};

  always_ff @(posedge clk) begin
    if (vs_we) begin
      value_mem[cnt_r[IDX_W-1:0]] <= in_tdata[VALUE_BITS-1:0];
    end
    rd_data_r <= value_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    e_nxt          = e_r;
    acc_nxt        = acc_r;
    res_ok_nxt     = res_ok_r;
    res_len_nxt    = res_len_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_len_nxt    = out_len_r;
    out_fail_nxt   = out_fail_r;
    dp_start       = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cnt_nxt = cnt_inc;
          if (in_tlast) begin
            n_nxt   = cnt_inc;
            cnt_nxt = '0;
            i_nxt   = '0;
            e_nxt   = '0;
            acc_nxt = '0;
            if (wcount_r == '0) begin
              res_ok_nxt  = 1'b1;
              res_len_nxt = '0;
              state_nxt   = S_FINISH;
            end else if (int'(wcount_r) > MAX_WINDOWS) begin
              res_ok_nxt  = 1'b0;
              res_len_nxt = '0;
              state_nxt   = S_FINISH;
            end else begin
              state_nxt = S_CHK;
            end
          end
        end
      end
      S_CHK, S_SUB: begin
        if (state_r == S_CHK && cond) begin
          state_nxt = S_ADD;
        end else if (state_r == S_CHK && e_r > i_r) begin
          state_nxt = S_SUB;
        end else begin
          if (state_r == S_SUB) begin
            acc_nxt = acc_r - ACC_W'(rd_data_r);
          end
          if (i_inc == n_r) begin
            dp_start  = 1'b1;
            state_nxt = S_DP;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_CHK;
            if (e_r < i_inc) begin
              e_nxt   = i_inc;
              acc_nxt = '0;
            end
          end
        end
      end
      S_ADD: begin
        acc_nxt   = acc_r + ACC_W'(rd_data_r);
        e_nxt     = e_r + LEN_W'(1);
        state_nxt = S_CHK;
      end
      S_DP: begin
        if (dp_stat.done) begin
          res_ok_nxt  = dp_stat.ok;
          res_len_nxt = dp_len;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_len_nxt    = res_ok_r ? len_ext[OUT_LEN_W-1:0] : '0;
          out_fail_nxt   = !res_ok_r;
          state_nxt      = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      target_r     <= TGT_RESET;
      wcount_r     <= WCNT_RESET;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_index == REG_TARGET_SUM) begin
        target_r <= cfg_data[TGT_W-1:0];
      end
      if (cfg_valid && cfg_index == REG_WINDOW_COUNT) begin
        wcount_r <= cfg_data[WCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    e_r        <= e_nxt;
    acc_r      <= acc_nxt;
    res_ok_r   <= res_ok_nxt;
    res_len_r  <= res_len_nxt;
    out_len_r  <= out_len_nxt;
    out_fail_r <= out_fail_nxt;
  end

  desw_dp #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .win_we  (win_we),
    .win_addr(i_r[IDX_W-1:0]),
    .win_data({win_valid, e_m1[IDX_W-1:0]}),
    .dp_start(dp_start),
    .dp_n    (n_r),
    .dp_m    (wcount_r),
    .dp_stat (dp_stat),
    .dp_len  (dp_len)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LEN_W'(MAX_ITEMS))
    else $error("load count beyond buffer depth");

  a_scan_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (e_r >= i_r && i_r < n_r))
    else $error("scan pointers out of order");

  a_dp_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    dp_stat.done |-> (state_r == S_DP))
    else $error("DP finished while not awaited");

endmodule

`default_nettype wire

### rtl/core/desw_dp.sv
// DP engine: window table and two ping-pong row memories, one position per cycle.
// Depends on desw_pkg.
`default_nettype none

module desw_dp import desw_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  localparam int IDX_W = $clog2(MAX_ITEMS),
  localparam int LEN_W = $clog2(MAX_ITEMS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              win_we,
  input  logic [IDX_W-1:0]  win_addr,
  input  logic [IDX_W:0]    win_data,   // {valid, end index}
  input  logic              dp_start,
  input  logic [LEN_W-1:0]  dp_n,
  input  logic [WCNT_W-1:0] dp_m,
  output dp_stat_t          dp_stat,
  output logic [LEN_W-1:0]  dp_len
);

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_START = 3'b010,
    D_RUN   = 3'b100
  } dstate_t;

  dstate_t state_r, state_nxt;

  logic [IDX_W:0] win_mem [MAX_ITEMS];
  logic [LEN_W:0] row_a [MAX_ITEMS+1];
  logic [LEN_W:0] row_b [MAX_ITEMS+1];

  logic [IDX_W:0]    win_rd_r;
  logic [LEN_W:0]    row_a_rd_r, row_b_rd_r;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [WCNT_W-1:0] m_r, m_nxt, pass_r, pass_nxt;
  logic              first_r, first_nxt, sel_r, sel_nxt;
  logic              iss_on_r, iss_on_nxt;
  logic [IDX_W-1:0]  iss_p_r, iss_p_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic [IDX_W-1:0]  s1_p_r, s1_p_nxt;
  logic              s2_v_r, s2_v_nxt, s2_wv_r, s2_wv_nxt;
  logic [IDX_W-1:0]  s2_p_r, s2_p_nxt;
  logic [LEN_W-1:0]  s2_len_r, s2_len_nxt;
  logic              best_ok_r, best_ok_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic              done_r, done_nxt;

  logic              s1_valid;
  logic [IDX_W-1:0]  s1_end;
  logic [LEN_W-1:0]  s1_len, row_raddr, row_waddr, t_len, cand;
  logic [LEN_W:0]    prev_rd, row_wdata;
  logic              t_ok, row_we;

  assign s1_valid  = win_rd_r[IDX_W];
  assign s1_end    = win_rd_r[IDX_W-1:0];
  assign row_raddr = LEN_W'(s1_end) + LEN_W'(1);
  assign s1_len    = LEN_W'(s1_end) - LEN_W'(s1_p_r) + LEN_W'(1);
  assign prev_rd   = sel_r ? row_a_rd_r : row_b_rd_r;
  // first pass: every suffix takes zero windows
  assign t_ok      = first_r | prev_rd[LEN_W];
  assign t_len     = first_r ? '0 : prev_rd[LEN_W-1:0];
  assign cand      = t_len + s2_len_r;

  assign row_we    = (state_r == D_START) || s2_v_r;
  assign row_waddr = (state_r == D_START) ? n_r : LEN_W'(s2_p_r);
  assign row_wdata = {best_ok_nxt, best_len_nxt};

  assign dp_stat = '{done: done_r, ok: best_ok_r};
  assign dp_len  = best_len_r;

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_addr] <= win_data;
    end
    win_rd_r <= win_mem[iss_p_r];
  end

  always_ff @(posedge clk) begin
    if (row_we && !sel_r) begin
      row_a[row_waddr] <= row_wdata;
    end
    if (row_we && sel_r) begin
      row_b[row_waddr] <= row_wdata;
    end
    row_a_rd_r <= row_a[row_raddr];
    row_b_rd_r <= row_b[row_raddr];
  end

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    m_nxt        = m_r;
    pass_nxt     = pass_r;
    first_nxt    = first_r;
    sel_nxt      = sel_r;
    iss_on_nxt   = iss_on_r;
    iss_p_nxt    = iss_p_r;
    s1_v_nxt     = 1'b0;
    s1_p_nxt     = s1_p_r;
    s2_v_nxt     = s1_v_r;
    s2_p_nxt     = s1_p_r;
    s2_wv_nxt    = s1_valid;
    s2_len_nxt   = s1_len;
    best_ok_nxt  = best_ok_r;
    best_len_nxt = best_len_r;
    done_nxt     = 1'b0;

    if (s2_v_r && s2_wv_r && t_ok && (!best_ok_r || cand > best_len_r)) begin
      best_ok_nxt  = 1'b1;
      best_len_nxt = cand;
    end

    case (state_r)
      D_IDLE: begin
        if (dp_start) begin
          n_nxt     = dp_n;
          m_nxt     = dp_m;
          pass_nxt  = WCNT_W'(1);
          first_nxt = 1'b1;
          sel_nxt   = 1'b0;
          state_nxt = D_START;
        end
      end
      D_START: begin
        iss_p_nxt    = IDX_W'(n_r - LEN_W'(1));
        iss_on_nxt   = 1'b1;
        best_ok_nxt  = 1'b0;
        best_len_nxt = '0;
        state_nxt    = D_RUN;
      end
      D_RUN: begin
        if (iss_on_r) begin
          s1_v_nxt = 1'b1;
          s1_p_nxt = iss_p_r;
          if (iss_p_r == '0) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_p_nxt = iss_p_r - IDX_W'(1);
          end
        end else if (!s1_v_r && !s2_v_r) begin
          if (pass_r == m_r) begin
            done_nxt  = 1'b1;
            state_nxt = D_IDLE;
          end else begin
            pass_nxt  = pass_r + WCNT_W'(1);
            first_nxt = 1'b0;
            sel_nxt   = ~sel_r;
            state_nxt = D_START;
          end
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= D_IDLE;
      iss_on_r   <= 1'b0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      done_r     <= 1'b0;
      best_ok_r  <= 1'b0;
      best_len_r <= '0;
    end else begin
      state_r    <= state_nxt;
      iss_on_r   <= iss_on_nxt;
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
      done_r     <= done_nxt;
      best_ok_r  <= best_ok_nxt;
      best_len_r <= best_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    m_r      <= m_nxt;
    pass_r   <= pass_nxt;
    first_r  <= first_nxt;
    sel_r    <= sel_nxt;
    iss_p_r  <= iss_p_nxt;
    s1_p_r   <= s1_p_nxt;
    s2_p_r   <= s2_p_nxt;
    s2_wv_r  <= s2_wv_nxt;
    s2_len_r <= s2_len_nxt;
  end

  a_stage_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || s2_v_r) |-> (state_r == D_RUN))
    else $error("DP pipeline active outside a pass");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!s1_v_r && !s2_v_r && state_r == D_IDLE))
    else $error("DP done with pipeline busy");

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    iss_on_r |-> (LEN_W'(iss_p_r) < n_r))
    else $error("DP issue position out of range");

endmodule

`default_nettype wire

### tb/tb_disjoint_exact_sum_windows_dp_top.sv
// Self-checking testbench for disjoint_exact_sum_windows_dp_top: a directed table, then
// random runs with planted exact-sum windows, long runs at full window count, and an overflow run at the end.
// Depends on desw_pkg and the RTL of the top level; results are checked by a local predictor.
`timescale 1ns / 100ps

module tb_disjoint_exact_sum_windows_dp_top;
  import desw_pkg::*;

  localparam int RUN_DEPTH     = DEF_MAX_ITEMS;
  localparam int WIN_LIMIT     = DEF_MAX_WINDOWS;
  localparam int VAL_W         = DEF_VALUE_BITS;
  localparam int IN_W          = ((VAL_W + 7) / 8) * 8;
  localparam int RANDOM_WORDS  = 1700;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_NS      = 30_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] len;
    logic                 fail;
  } dp_answer_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [VAL_W-1:0]      value;
    logic                  last;
    logic                  typed;
    logic [OUT_LEN_W-1:0]  len;
    logic                  fail;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic [TGT_W-1:0]  cur_target = TGT_RESET;
  logic [WCNT_W-1:0] cur_count = WCNT_RESET;
  logic [VAL_W-1:0]  run_values [RUN_DEPTH];
  int                run_fill = 0;
  bit                win_ok [RUN_DEPTH];
  int                win_stop [RUN_DEPTH];
  bit                best_ok_prev [RUN_DEPTH+1];
  bit                best_ok_cur [RUN_DEPTH+1];
  int                best_len_prev [RUN_DEPTH+1];
  int                best_len_cur [RUN_DEPTH+1];

  dp_answer_t answers [$];
  dp_answer_t head_answer;
  plan_row_t  plan [$];

  bit calm_phase = 1'b0;
  int err_count = 0;
  int words_sent = 0;
  int runs_closed = 0;
  int results_seen = 0;
  int failed_runs = 0;
  int longest_len = 0;
  int max_count = 0;

  disjoint_exact_sum_windows_dp_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // shortest window from each start whose sum hits the target exactly
  function automatic void scan_exact_windows(int n);
    int i;
    int e;
    longint unsigned acc;
    e = 0;
    acc = 0;
    for (i = 0; i < n; i++) begin
      if (e < i) begin
        e = i;
        acc = 0;
      end
      while (e < n && (acc < cur_target || e == i)) begin
        acc += run_values[e];
        e++;
      end
      win_ok[i] = (e > i) && (acc == cur_target);
      win_stop[i] = win_ok[i] ? e - 1 : 0;
      if (e > i) acc -= run_values[i];
    end
  endfunction

  // two-row DP: exactly m disjoint windows, longest total
  function automatic dp_answer_t pick_disjoint_windows(int n, int m);
    int c;
    int p;
    int q;
    int e;
    int cand;
    int len;
    bit ok;
    dp_answer_t ans;
    for (p = 0; p <= n; p++) begin
      best_ok_prev[p] = 1'b1;
      best_len_prev[p] = 0;
    end
    for (c = 1; c <= m; c++) begin
      best_ok_cur[n] = 1'b0;
      best_len_cur[n] = 0;
      for (q = n - 1; q >= 0; q--) begin
        ok = best_ok_cur[q+1];
        len = best_len_cur[q+1];
        if (win_ok[q]) begin
          e = win_stop[q];
          if (best_ok_prev[e+1]) begin
            cand = best_len_prev[e+1] + e - q + 1;
            if (!ok || cand > len) begin
              ok = 1'b1;
              len = cand;
            end
          end
        end
        best_ok_cur[q] = ok;
        best_len_cur[q] = len;
      end
      for (p = 0; p <= n; p++) begin
        best_ok_prev[p] = best_ok_cur[p];
        best_len_prev[p] = best_len_cur[p];
      end
    end
    ans.fail = !best_ok_prev[0];
    len = ans.fail ? 0 : best_len_prev[0];
    ans.len = len[OUT_LEN_W-1:0];
    return ans;
  endfunction

  function automatic bit absorb_word(logic [VAL_W-1:0] value, logic last,
                                     output dp_answer_t ans);
    int n;
    int k;
    ans = '0;
    if (run_fill < RUN_DEPTH) begin
      run_values[run_fill] = value;
      run_fill++;
    end
    if (!last) return 1'b0;
    n = run_fill;
    run_fill = 0;
    for (k = 0; k < RUN_DEPTH; k++) win_ok[k] = 1'b0;
    if (cur_count > WIN_LIMIT) begin
      ans.fail = 1'b1;
      return 1'b1;
    end
    scan_exact_windows(n);
    ans = pick_disjoint_windows(n, cur_count);
    return 1'b1;
  endfunction

  function automatic int draw_pause();
    return calm_phase ? 0 : $urandom_range(6, 0);
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    return '{ROW_CFG, idx, data, '0, 1'b0, 1'b0, '0, 1'b0};
  endfunction

  function automatic plan_row_t word_row(logic [VAL_W-1:0] value, logic last, logic typed,
                                         logic [OUT_LEN_W-1:0] len, logic fail);
    return '{ROW_WORD, '0, '0, value, last, typed, len, fail};
  endfunction

  function automatic void add_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_TARGET_SUM) begin
      cur_target = data[TGT_W-1:0];
    end else if (index == REG_WINDOW_COUNT) begin
      cur_count = data[WCNT_W-1:0];
      if (cur_count > max_count) max_count = cur_count;
    end
  endtask

  task automatic send_word(logic [VAL_W-1:0] value, logic last, logic typed,
                           dp_answer_t typed_ans);
    int pause;
    dp_answer_t ans;
    pause = draw_pause();
    cfg_valid <= 1'b0;
    if (pause > 0) begin
      in_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (absorb_word(value, last, ans)) begin
      runs_closed++;
      answers.insert(answers.size(), typed ? typed_ans : ans);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly planted windows summing to the target, with filler, noise and broken pieces
  task automatic send_run(int vmax, int max_len);
    logic [VAL_W-1:0] words [$];
    int goal;
    int rem;
    int piece;
    int i;
    goal = $urandom_range(max_len, 1);
    while (words.size() < goal) begin
      if ($urandom_range(9, 0) < 6) begin
        if (cur_target == 0) begin
          words = {words, VAL_W'(0)};
        end else begin
          rem = cur_target;
          while (rem > 0 && words.size() < 40) begin
            if (rem > vmax) piece = $urandom_range(vmax, 1);
            else piece = $urandom_range(1, 0) ? rem : $urandom_range(rem, 1);
            if ($urandom_range(19, 0) == 0) piece = $urandom_range(vmax, 1);
            words = {words, piece[VAL_W-1:0]};
            rem -= piece;
          end
        end
      end else if ($urandom_range(19, 0) == 0) begin
        piece = $urandom_range(16'hFFFF, 0);
        words = {words, piece[VAL_W-1:0]};
      end else begin
        piece = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(vmax, 1);
        words = {words, piece[VAL_W-1:0]};
      end
    end
    for (i = 0; i < words.size(); i++) send_word(words[i], i == words.size() - 1, 1'b0, '0);
  endtask

  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_pause();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (answers.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: tdata=%0d tuser=%0b",
                                  out_tdata, out_tuser));
      end else begin
        head_answer = answers.pop_front();
        if (out_tdata !== {{(OUT_TDATA_W-OUT_LEN_W){1'b0}}, head_answer.len})
          report_mismatch($sformatf("best_length got %0d want %0d", out_tdata, head_answer.len));
        if (out_tuser !== head_answer.fail)
          report_mismatch($sformatf("no_solution got %0b want %0b", out_tuser, head_answer.fail));
        if (head_answer.fail) failed_runs++;
        else if (head_answer.len > longest_len) longest_len = head_answer.len;
      end
    end
  end

  initial begin
    bit after_word;
    int rand_start;
    int vmax;
    int target;
    int count;
    int i;
    dp_answer_t typed_ans;

    // reset values: target 1, count 1
    add_row(word_row(16'd1,     1'b1, 1'b1, 13'd1, 1'b0));
    add_row(word_row(16'hFFFF,  1'b1, 1'b1, 13'd0, 1'b1));
    // upper data bits must be masked off
    add_row(cfg_row(REG_TARGET_SUM,   32'hF000_0005));
    add_row(cfg_row(REG_WINDOW_COUNT, 32'h0000_0002));
    add_row(word_row(16'd2, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd3, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd5, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd1, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd4, 1'b1, 1'b0, '0, 1'b0));
    // zero windows always succeed
    add_row(cfg_row(REG_WINDOW_COUNT, 32'h0000_0000));
    add_row(word_row(16'd7, 1'b1, 1'b1, 13'd0, 1'b0));
    // counts above the window limit
    add_row(cfg_row(REG_WINDOW_COUNT, 32'hABCD_0081));
    add_row(word_row(16'd5, 1'b1, 1'b1, 13'd0, 1'b1));
    add_row(cfg_row(REG_WINDOW_COUNT, 32'h0000_01FF));
    add_row(word_row(16'd5, 1'b1, 1'b1, 13'd0, 1'b1));
    // zero target matches a single zero value
    add_row(cfg_row(REG_TARGET_SUM,   32'h0000_0000));
    add_row(cfg_row(REG_WINDOW_COUNT, 32'h0000_0001));
    add_row(word_row(16'd3, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd0, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd4, 1'b1, 1'b0, '0, 1'b0));
    // largest target is out of reach
    add_row(cfg_row(REG_TARGET_SUM, 32'hFFFF_FFFF));
    add_row(word_row(16'hFFFF, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'hFFFF, 1'b1, 1'b1, 13'd0, 1'b1));
    // writes to unused indexes change nothing
    add_row(cfg_row(REG_TARGET_SUM,   32'h0000_0003));
    add_row(cfg_row(REG_WINDOW_COUNT, 32'h0000_0001));
    add_row(cfg_row(REG_SPARE_LO,     32'h0000_0005));
    add_row(cfg_row(REG_SPARE_HI,     32'h0000_0002));
    add_row(word_row(16'd1, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd1, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd1, 1'b0, 1'b0, '0, 1'b0));
    add_row(word_row(16'd1, 1'b1, 1'b0, '0, 1'b0));
    // full window count on a one-word run
    add_row(cfg_row(REG_TARGET_SUM,   32'h0000_0001));
    add_row(cfg_row(REG_WINDOW_COUNT, 32'h0000_0080));
    add_row(word_row(16'd1, 1'b1, 1'b1, 13'd0, 1'b1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    after_word = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (after_word) drain_results();
        after_word = 1'b0;
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        typed_ans.len = plan[r].len;
        typed_ans.fail = plan[r].fail;
        send_word(plan[r].value, plan[r].last, plan[r].typed, typed_ans);
        after_word = 1'b1;
      end
    end

    rand_start = words_sent;
    while (words_sent - rand_start < RANDOM_WORDS) begin
      drain_results();
      case ($urandom_range(4, 0))
        0:       vmax = 1;
        1:       vmax = 3;
        2:       vmax = 15;
        3:       vmax = 255;
        default: vmax = 65535;
      endcase
      case ($urandom_range(9, 0))
        0:       target = 0;
        1:       target = $urandom_range(32'h0FFF_FFFF, 0);
        default: target = $urandom_range(vmax * 3, 1);
      endcase
      case ($urandom_range(11, 0))
        0:       count = 0;
        1:       count = $urandom_range(255, 129);
        default: count = $urandom_range(3, 1);
      endcase
      write_reg(REG_TARGET_SUM, ($urandom & 32'hF000_0000) | target);
      write_reg(REG_WINDOW_COUNT, ($urandom & 32'hFFFF_FF00) | count);
      calm_phase = ($urandom_range(4, 0) == 0);
      repeat ($urandom_range(8, 3)) begin
        if ($urandom_range(7, 0) == 0) drain_results();
        send_run(vmax, 20);
      end
    end

    // full window count on long runs
    drain_results();
    calm_phase = 1'b0;
    write_reg(REG_TARGET_SUM, 32'd2);
    write_reg(REG_WINDOW_COUNT, 32'd128);
    for (i = 0; i < 300; i++) send_word($urandom_range(2, 1), i == 299, 1'b0, '0);
    for (i = 0; i < 260; i++) send_word(16'd1, i == 259, 1'b0, '0);

    // overflow: words past the buffer are dropped, the dropped tlast still closes the run
    drain_results();
    write_reg(REG_TARGET_SUM, 32'd64);
    write_reg(REG_WINDOW_COUNT, 32'd64);
    for (i = 0; i < RUN_DEPTH + 4; i++) send_word(16'd1, i == RUN_DEPTH + 3, 1'b0, '0);

    drain_results();
    repeat (20) @(posedge clk);
    if (answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", answers.size()));

    $display("Covered %0d words over %0d runs; %0d results checked, %0d with no solution.",
             words_sent, runs_closed, results_seen, failed_runs);
    $display("Window counts written up to %0d; longest total length %0d.",
             max_count, longest_len);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
